@@ rtl/jlt_pkg.sv @@
// ----------------------------------------------------------------------------
// jlt_pkg
// Shared types, character codes and literal-match helpers for the JSON line
// tokenizer.
// ----------------------------------------------------------------------------
package jlt_pkg;

  // Column geometry
  localparam int MAX_LINE = 4096;
  localparam int START_W  = 12;
  localparam int END_W    = 13;
  localparam int KIND_W   = 3;

  // Character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_STR  = 3'd1,
    M_ESC  = 3'd2,
    M_HELD = 3'd3,
    M_NUM  = 3'd4,
    M_WORD = 3'd5
  } lex_mode_t;

  typedef enum logic [KIND_W-1:0] {
    K_STRING  = 3'd0,
    K_KEY     = 3'd1,
    K_NUMBER  = 3'd2,
    K_KEYWORD = 3'd3,
    K_WORD    = 3'd4
  } token_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } in_beat_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [END_W-1:0]   stop;
    token_kind_t        kind;
    logic               last;
  } token_t;

  // Up to two tokens per input byte, already compacted and flagged
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } emit_t;

  typedef struct packed {
    logic [2:0] len;
    logic [2:0] mask;
  } word_state_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_wordbyte(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_UNDER);
  endfunction

  function automatic logic is_numbyte(input logic [7:0] c);
    return is_digit(c) || (c == CH_DOT) || (c == CH_LOW_E) || (c == CH_UP_E) ||
           (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  // Characters of "true", "false" and "null" by position
  function automatic logic [7:0] lit_true(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = 8'h74;
      2'd1: r = 8'h72;
      2'd2: r = 8'h75;
      default: r = 8'h65;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] lit_false(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0: r = 8'h66;
      3'd1: r = 8'h61;
      3'd2: r = 8'h6C;
      3'd3: r = 8'h73;
      default: r = 8'h65;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] lit_null(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = 8'h6E;
      2'd1: r = 8'h75;
      default: r = 8'h6C;
    endcase
    return r;
  endfunction

  // Extend a word by one byte: narrow the literal candidates, bump the length
  function automatic word_state_t word_feed(input word_state_t ws, input logic [7:0] c);
    word_state_t r;
    r = ws;
    if (!((ws.len < 3'd4) && (c == lit_true(ws.len[1:0])))) r.mask[0] = 1'b0;
    if (!((ws.len < 3'd5) && (c == lit_false(ws.len)))) r.mask[1] = 1'b0;
    if (!((ws.len < 3'd4) && (c == lit_null(ws.len[1:0])))) r.mask[2] = 1'b0;
    if (ws.len != 3'd7) r.len = ws.len + 3'd1;
    return r;
  endfunction

  function automatic token_kind_t word_kind(input word_state_t ws);
    logic kw;
    kw = (ws.mask[0] && (ws.len == 3'd4)) || (ws.mask[1] && (ws.len == 3'd5)) ||
         (ws.mask[2] && (ws.len == 3'd4));
    return kw ? K_KEYWORD : K_WORD;
  endfunction

endpackage

@@ rtl/jlt_in_stage.sv @@
// ----------------------------------------------------------------------------
// jlt_in_stage
// Input register: captures one byte beat and holds it until the lexer takes it.
// ----------------------------------------------------------------------------
module jlt_in_stage import jlt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  logic [7:0] s_tdata,   // ch[7:0]
  input  logic     s_tlast,     // line_end
  input  logic     take,
  output logic     valid,
  output in_beat_t beat
);

  logic accept;

  // Free when empty or when the held beat leaves this cycle
  assign s_tready = !valid || take;
  assign accept   = s_tvalid && s_tready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= accept || (valid && !take);
    end
  end

  // Load the payload
  always_ff @(posedge clk) begin
    if (accept) begin
      beat <= '{ch: s_tdata, line_end: s_tlast};
    end
  end

endmodule

@@ rtl/jlt_lexer.sv @@
// ----------------------------------------------------------------------------
// jlt_lexer
// Lexer state and combinational step: classifies one byte, closes tokens and
// applies the line end, producing up to two tokens.
// ----------------------------------------------------------------------------
module jlt_lexer import jlt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  in_beat_t beat,
  output emit_t    emit
);

  lex_mode_t          mode, mode_next;
  logic [END_W-1:0]   column, column_next;
  logic [START_W-1:0] open_begin, open_begin_next;
  logic [START_W-1:0] held_begin, held_begin_next;
  logic [END_W-1:0]   held_stop, held_stop_next;
  word_state_t        word, word_next;

  logic               at_max;
  logic [START_W-1:0] bpos;
  logic [END_W-1:0]   end1;
  lex_mode_t          mode_a;
  logic [START_W-1:0] open_a;
  word_state_t        word_a;
  logic               restart;
  logic               v0, v1;
  token_t             t0, t1;
  logic [7:0]         c;

  localparam word_state_t WORD_CLEAR = '{len: 3'd0, mask: 3'b111};

  assign c      = beat.ch;
  assign at_max = (column >= END_W'(MAX_LINE));
  assign bpos   = at_max ? START_W'(MAX_LINE - 1) : column[START_W-1:0];
  assign end1   = at_max ? END_W'(MAX_LINE) : (column + END_W'(1));

  // Lex the byte, then apply the line end
  always_comb begin
    mode_a          = mode;
    open_a          = open_begin;
    word_a          = word;
    held_begin_next = held_begin;
    held_stop_next  = held_stop;
    restart         = 1'b0;
    v0              = 1'b0;
    t0              = '{start: open_begin, stop: column, kind: K_NUMBER, last: 1'b0};

    unique case (mode)
      M_STR: begin
        if (c == CH_BSLASH) begin
          mode_a = M_ESC;
        end else if (c == CH_QUOTE) begin
          held_begin_next = open_begin;
          held_stop_next  = end1;
          mode_a          = M_HELD;
        end
      end
      M_ESC: begin
        mode_a = M_STR;
      end
      M_HELD: begin
        if ((c != CH_SPACE) && (c != CH_TAB)) begin
          v0      = 1'b1;
          t0      = '{start: held_begin, stop: held_stop,
                      kind: (c == CH_COLON) ? K_KEY : K_STRING, last: 1'b0};
          restart = 1'b1;
        end
      end
      M_NUM: begin
        if (!is_numbyte(c)) begin
          v0      = 1'b1;
          restart = 1'b1;
        end
      end
      M_WORD: begin
        if (is_wordbyte(c)) begin
          word_a = word_feed(word, c);
        end else begin
          v0      = 1'b1;
          t0.kind = word_kind(word);
          restart = 1'b1;
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    // Start a new token from idle
    if (restart) begin
      mode_a = M_IDLE;
      priority if (c == CH_QUOTE) begin
        mode_a = M_STR;
        open_a = bpos;
      end else if (is_digit(c) || (c == CH_MINUS)) begin
        mode_a = M_NUM;
        open_a = bpos;
      end else if (is_wordbyte(c)) begin
        mode_a = M_WORD;
        open_a = bpos;
        word_a = word_feed(WORD_CLEAR, c);
      end
    end

    // Close any open token at line end
    v1 = 1'b0;
    t1 = '{start: open_a, stop: end1, kind: K_STRING, last: 1'b1};
    if (beat.line_end) begin
      unique case (mode_a)
        M_STR, M_ESC: v1 = 1'b1;
        M_HELD: begin
          v1       = 1'b1;
          t1.start = held_begin_next;
          t1.stop  = held_stop_next;
        end
        M_NUM: begin
          v1      = 1'b1;
          t1.kind = K_NUMBER;
        end
        M_WORD: begin
          v1      = 1'b1;
          t1.kind = word_kind(word_a);
        end
        default: v1 = 1'b0;
      endcase
      mode_next   = M_IDLE;
      column_next = '0;
      word_next   = WORD_CLEAR;
    end else begin
      mode_next   = mode_a;
      column_next = end1;
      word_next   = word_a;
    end
    open_begin_next = open_a;

    // Compact the two slots and flag the last one
    emit.count = 2'(v0) + 2'(v1);
    emit.tok1  = t1;
    if (v0) begin
      emit.tok0      = t0;
      emit.tok0.last = !v1;
    end else begin
      emit.tok0 = t1;
    end
  end

  // Advance state on each taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      column     <= '0;
      open_begin <= '0;
      held_begin <= '0;
      held_stop  <= '0;
      word       <= WORD_CLEAR;
    end else if (take) begin
      mode       <= mode_next;
      column     <= column_next;
      open_begin <= open_begin_next;
      held_begin <= held_begin_next;
      held_stop  <= held_stop_next;
      word       <= word_next;
    end
  end

`ifndef SYNTHESIS
  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    take && beat.line_end |=> (mode == M_IDLE) && (column == '0))
    else $error("line end did not return lexer to idle at column zero");
  a_col_sat: assert property (@(posedge clk) disable iff (rst)
    column <= END_W'(MAX_LINE))
    else $error("column passed the line limit");
  a_word_len: assert property (@(posedge clk) disable iff (rst)
    (mode == M_WORD) |-> (word.len != 3'd0))
    else $error("open word with zero length");
`endif

endmodule

@@ rtl/jlt_out_queue.sv @@
// ----------------------------------------------------------------------------
// jlt_out_queue
// Four-entry token queue: takes up to two tokens per cycle while it has room for two, sends one beat.
// ----------------------------------------------------------------------------
module jlt_out_queue import jlt_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  emit_t  emit,
  output logic   room,
  output logic   m_tvalid,
  input  logic   m_tready,
  output token_t head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  token_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [PTR_W:0]     count, count_next;
  logic [1:0]         push_n;
  logic               pop;

  assign push_n   = push ? emit.count : 2'd0;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign room     = (count <= (PTR_W+1)'(DEPTH - 2));
  assign head     = entries[rd_ptr];
  assign count_next = count + (PTR_W+1)'(push_n) - (PTR_W+1)'(pop);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  // Write one or two tokens
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= emit.tok0;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= emit.tok1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> ((count + (PTR_W+1)'(push_n)) <= (PTR_W+1)'(DEPTH)))
    else $error("token queue overflow");
  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push |-> room)
    else $error("push without room");
`endif

endmodule

@@ rtl/json_line_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// json_line_tokenizer_top
// Streaming JSON line lexer: one byte per beat in, (start, end, kind) tokens
// out.
//
//   channel  dir  tdata               tuser        tlast
//   s_*      in   ch[7:0]             -            line_end
//   m_*      out  start[11:0],        kind[2:0]    last_of_run
//                 end[24:12]
//
// One byte per cycle; a byte is held in the input register until the lexer
// takes it, and its tokens are registered in the token queue before m_*.
// The lexer step runs whenever the four-entry token queue has room for two
// tokens, so the byte rate drops while the output side stalls or bytes yield more tokens than the queue sends.
// rst is synchronous: lexer idle at column zero, queue empty.
// ----------------------------------------------------------------------------
module json_line_tokenizer_top import jlt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // ch[7:0]
  input  logic        s_tlast,   // line_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // token_start[11:0], token_end[24:12], zero fill
  output logic [2:0]  m_tuser,   // token_kind[2:0]
  output logic        m_tlast    // last_of_run
);

  logic     in_valid;
  in_beat_t beat;
  logic     take;
  logic     room;
  emit_t    emit;
  token_t   head;

  assign take = in_valid && room;

  jlt_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .take     (take),
    .valid    (in_valid),
    .beat     (beat)
  );

  jlt_lexer u_lex (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .beat (beat),
    .emit (emit)
  );

  jlt_out_queue u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (take),
    .emit     (emit),
    .room     (room),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  // Pack the head token
  assign m_tdata = {7'd0, head.stop, head.start};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule
